FILE: rtl/rbs_pkg.sv
package rbs_pkg;

    localparam int FracBits = 16;
    localparam int QBits = 31;

    // Pipeline stage map.
    localparam int StgPrep = 0;
    localparam int StgOvf = 1;
    localparam int StgDivFirst = 2;
    localparam int StgDivLast = StgDivFirst + QBits - 1;
    localparam int StgOrder = StgDivLast + 1;
    localparam int StgInterval = StgOrder + 1;
    localparam int StgMul = StgInterval + 1;
    localparam int NumStages = StgMul + 1;

    localparam logic [31:0] SatMax = 32'h7fff_ffff;
    localparam logic [31:0] SatMin = 32'h8000_0000;

    localparam logic [15:0] ThresholdReset = 16'd66;
    localparam logic [30:0] TLimitReset = 31'h7fff_ffff;

    typedef enum logic {
        CFG_THRESHOLD = 1'b0,
        CFG_T_LIMIT   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic [30:0]        t_entry;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } out_item_t;

    // Lane 2a divides for the minimum plane of axis a, lane 2a+1 for the maximum plane.
    typedef struct packed {
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
        logic [2:0]       par;
        logic [2:0]       par_miss;
        logic [2:0][31:0] dmag;
        logic [5:0][48:0] rem;
        logic [5:0][30:0] q;
        logic [5:0]       neg;
        logic [5:0]       ovf;
        logic [5:0][31:0] t;
        logic [30:0]      tmin;
        logic             miss;
        logic [2:0][63:0] prod;
    } pipe_t;

endpackage

FILE: rtl/rbs_in_if.sv
interface rbs_in_if;
    logic              valid;
    logic              ready;
    rbs_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/rbs_out_if.sv
interface rbs_out_if;
    logic               valid;
    logic               ready;
    rbs_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ray_box_slab_intersect.sv
// Channel   Direction  Transfer when          Payload
// ray       in         ray.valid & ray.ready  origin, direction, box corners
// result    out        result.valid & ready   hit, t_entry, point_x/y/z
// cfg       in         cfg_we                 cfg_index, cfg_data
//
// One ray per cycle is taken while the skid buffer is empty.
// The depth is set by the six restoring dividers, one quotient bit per stage.
// rst_n clears all valid bits and loads the register reset values.
// A result stalled at the output moves into a one-entry skid buffer; ray.ready
// drops the cycle after and the whole pipeline holds until it drains.
module ray_box_slab_intersect (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  rbs_pkg::cfg_index_t cfg_index,
    input  logic [30:0]         cfg_data,
    rbs_in_if.sink              ray,
    rbs_out_if.source           result
);

    logic [15:0] threshold_reg;
    logic [30:0] t_limit_reg;

    rbs_pkg::pipe_t pipe_reg [rbs_pkg::NumStages];
    rbs_pkg::pipe_t pipe_next [rbs_pkg::NumStages];
    logic [rbs_pkg::NumStages-1:0] valid_reg;

    rbs_pkg::out_item_t res_next;
    rbs_pkg::out_item_t out_reg;
    rbs_pkg::out_item_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic adv;
    logic mov;

    logic [2:0][31:0] org_in, dir_in, min_in, max_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= rbs_pkg::ThresholdReset;
            t_limit_reg   <= rbs_pkg::TLimitReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rbs_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data[15:0];
                rbs_pkg::CFG_T_LIMIT:   t_limit_reg <= cfg_data;
                default:                threshold_reg <= threshold_reg;
            endcase
        end
    end

    assign org_in = {ray.data.origin_z, ray.data.origin_y, ray.data.origin_x};
    assign dir_in = {ray.data.dir_z, ray.data.dir_y, ray.data.dir_x};
    assign min_in = {ray.data.box_min_z, ray.data.box_min_y, ray.data.box_min_x};
    assign max_in = {ray.data.box_max_z, ray.data.box_max_y, ray.data.box_max_x};

    always_comb
    begin
        logic signed [31:0] o, d, lo, hi, plane, ta, tb;
        logic [31:0]        dmag, qs;
        logic signed [32:0] diff, lo_b, hi_b;
        logic [48:0]        num;
        logic [63:0]        trial;
        int                 lane, k;

        // Plane differences, magnitudes and the parallel test.
        pipe_next[rbs_pkg::StgPrep] = '0;
        for (int a = 0; a < 3; a++)
        begin
            o  = signed'(org_in[a]);
            d  = signed'(dir_in[a]);
            lo = signed'(min_in[a]);
            hi = signed'(max_in[a]);
            dmag = d[31] ? (~dir_in[a] + 32'd1) : dir_in[a];
            pipe_next[rbs_pkg::StgPrep].org[a] = org_in[a];
            pipe_next[rbs_pkg::StgPrep].dir[a] = dir_in[a];
            pipe_next[rbs_pkg::StgPrep].dmag[a] = dmag;
            pipe_next[rbs_pkg::StgPrep].par[a] = (d == 32'sd0) ||
                                                 (dmag < {16'b0, threshold_reg});
            pipe_next[rbs_pkg::StgPrep].par_miss[a] = (o < lo) || (o > hi);
            for (int p = 0; p < 2; p++)
            begin
                lane = 2 * a + p;
                plane = (p == 1) ? hi : lo;
                diff = {plane[31], plane} - {o[31], o};
                num = {diff, 16'b0};
                pipe_next[rbs_pkg::StgPrep].neg[lane] = diff[32] ^ d[31];
                pipe_next[rbs_pkg::StgPrep].rem[lane] = diff[32] ? (~num + 49'd1) : num;
            end
        end

        // A quotient of 2^31 or more saturates.
        pipe_next[rbs_pkg::StgOvf] = pipe_reg[rbs_pkg::StgOvf-1];
        for (int l = 0; l < 6; l++)
        begin
            pipe_next[rbs_pkg::StgOvf].ovf[l] =
                {15'b0, pipe_reg[rbs_pkg::StgOvf-1].rem[l]} >=
                {1'b0, pipe_reg[rbs_pkg::StgOvf-1].dmag[l/2], 31'b0};
        end

        // One restoring quotient bit per stage, most significant first.
        for (int s = rbs_pkg::StgDivFirst; s <= rbs_pkg::StgDivLast; s++)
        begin
            k = rbs_pkg::StgDivLast - s;
            pipe_next[s] = pipe_reg[s-1];
            for (int l = 0; l < 6; l++)
            begin
                trial = {32'b0, pipe_reg[s-1].dmag[l/2]} << k;
                if (!pipe_reg[s-1].ovf[l] && ({15'b0, pipe_reg[s-1].rem[l]} >= trial))
                begin
                    pipe_next[s].rem[l] = pipe_reg[s-1].rem[l] - trial[48:0];
                    pipe_next[s].q[l][k] = 1'b1;
                end
            end
        end

        // Signed, saturated plane times, ordered near then far.
        pipe_next[rbs_pkg::StgOrder] = pipe_reg[rbs_pkg::StgOrder-1];
        for (int l = 0; l < 6; l++)
        begin
            qs = {1'b0, pipe_reg[rbs_pkg::StgOrder-1].q[l]};
            if (pipe_reg[rbs_pkg::StgOrder-1].ovf[l])
                pipe_next[rbs_pkg::StgOrder].t[l] =
                    pipe_reg[rbs_pkg::StgOrder-1].neg[l] ? rbs_pkg::SatMin : rbs_pkg::SatMax;
            else
                pipe_next[rbs_pkg::StgOrder].t[l] =
                    pipe_reg[rbs_pkg::StgOrder-1].neg[l] ? (~qs + 32'd1) : qs;
        end
        for (int a = 0; a < 3; a++)
        begin
            ta = signed'(pipe_next[rbs_pkg::StgOrder].t[2*a]);
            tb = signed'(pipe_next[rbs_pkg::StgOrder].t[2*a+1]);
            if (ta > tb)
            begin
                pipe_next[rbs_pkg::StgOrder].t[2*a]   = tb;
                pipe_next[rbs_pkg::StgOrder].t[2*a+1] = ta;
            end
        end

        // Narrow [0, t_limit] by every non-parallel axis.
        pipe_next[rbs_pkg::StgInterval] = pipe_reg[rbs_pkg::StgInterval-1];
        lo_b = 33'sd0;
        hi_b = signed'({2'b0, t_limit_reg});
        pipe_next[rbs_pkg::StgInterval].miss = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            ta = signed'(pipe_reg[rbs_pkg::StgInterval-1].t[2*a]);
            tb = signed'(pipe_reg[rbs_pkg::StgInterval-1].t[2*a+1]);
            if (pipe_reg[rbs_pkg::StgInterval-1].par[a])
            begin
                if (pipe_reg[rbs_pkg::StgInterval-1].par_miss[a])
                    pipe_next[rbs_pkg::StgInterval].miss = 1'b1;
            end
            else
            begin
                if (signed'({ta[31], ta}) > lo_b)
                    lo_b = signed'({ta[31], ta});
                if (signed'({tb[31], tb}) < hi_b)
                    hi_b = signed'({tb[31], tb});
            end
        end
        if (lo_b > hi_b)
            pipe_next[rbs_pkg::StgInterval].miss = 1'b1;
        pipe_next[rbs_pkg::StgInterval].tmin = lo_b[30:0];

        pipe_next[rbs_pkg::StgMul] = pipe_reg[rbs_pkg::StgMul-1];
        for (int a = 0; a < 3; a++)
        begin
            pipe_next[rbs_pkg::StgMul].prod[a] =
                64'(signed'(pipe_reg[rbs_pkg::StgMul-1].dir[a]) *
                    signed'({1'b0, pipe_reg[rbs_pkg::StgMul-1].tmin}));
        end
    end

    // Entry point: floor shift of the product, add the origin, saturate.
    always_comb
    begin
        logic signed [48:0] sum;
        logic [2:0][31:0]   pt;

        for (int a = 0; a < 3; a++)
        begin
            sum = signed'({pipe_reg[rbs_pkg::StgMul].prod[a][63],
                           pipe_reg[rbs_pkg::StgMul].prod[a][63:16]}) +
                  signed'({{17{pipe_reg[rbs_pkg::StgMul].org[a][31]}},
                           pipe_reg[rbs_pkg::StgMul].org[a]});
            if (sum > 49'sh0_7fff_ffff)
                pt[a] = rbs_pkg::SatMax;
            else if (sum < -49'sh0_8000_0000)
                pt[a] = rbs_pkg::SatMin;
            else
                pt[a] = sum[31:0];
        end
        if (pipe_reg[rbs_pkg::StgMul].miss)
            res_next = '0;
        else
        begin
            res_next.hit     = 1'b1;
            res_next.t_entry = pipe_reg[rbs_pkg::StgMul].tmin;
            res_next.point_x = pt[0];
            res_next.point_y = pt[1];
            res_next.point_z = pt[2];
        end
    end

    assign adv = !skid_valid_reg;
    assign mov = adv && valid_reg[rbs_pkg::NumStages-1];
    assign ray.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[rbs_pkg::NumStages-2:0], ray.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < rbs_pkg::NumStages; s++)
                pipe_reg[s] <= pipe_next[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg  <= skid_valid_reg || mov;
            skid_valid_reg <= 1'b0;
        end
        else if (mov)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
            out_reg <= skid_valid_reg ? skid_reg : res_next;
        else if (mov)
            skid_reg <= res_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

FILE: rtl/rbs_checker.sv
module rbs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input rbs_pkg::out_item_t out_data
);

    // A result waiting for a transfer stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

    // A miss carries no entry time and no point.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.t_entry == '0 &&
        out_data.point_x == '0 && out_data.point_y == '0 && out_data.point_z == '0)
    else $error("miss with nonzero payload");

    // Input back-pressure only follows an output stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("ray channel stalled without an output stall");

    // Nothing is offered while reset is held.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
    else $error("result offered during reset");

endmodule

bind ray_box_slab_intersect rbs_checker u_rbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (ray.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
